[sv/scc_pkg.sv]
// Package with shared types, register indexes and constants of the servo countdown controller.
package scc_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int FRAMES_W    = 17;
  localparam int TOTAL_W     = 18;

  localparam logic [FRAMES_W-1:0] FRAMES_MAX = 17'h1FFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BATTERY_CODE    = 3'd0,
    REG_HIGH_THRESHOLD  = 3'd1,
    REG_LOW_THRESHOLD   = 3'd2,
    REG_DEBOUNCE        = 3'd3,
    REG_BLINK_RELOAD    = 3'd4,
    REG_BASE_FRAMES     = 3'd5,
    REG_FRAMES_PER_STEP = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_COUNT  = 2'd1,
    MODE_ACTIVE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SHOW_BATT = 2'd0,
    SHOW_OFF  = 2'd1,
    SHOW_BLUE = 2'd2
  } show_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t COLOR_GREEN  = '{red: 8'd0,  green: 8'd25, blue: 8'd0};
  localparam rgb_t COLOR_PURPLE = '{red: 8'd30, green: 8'd0,  blue: 8'd11};
  localparam rgb_t COLOR_RED    = '{red: 8'd80, green: 8'd0,  blue: 8'd0};
  localparam rgb_t COLOR_BLUE   = '{red: 8'd0,  green: 8'd0,  blue: 8'd40};
  localparam rgb_t COLOR_OFF    = '{red: 8'd0,  green: 8'd0,  blue: 8'd0};

  localparam logic [7:0] RST_BATTERY_CODE    = 8'd0;
  localparam logic [7:0] RST_HIGH_THRESHOLD  = 8'd43;
  localparam logic [7:0] RST_LOW_THRESHOLD   = 8'd46;
  localparam logic [3:0] RST_DEBOUNCE        = 4'd5;
  localparam logic [6:0] RST_BLINK_RELOAD    = 7'd25;
  localparam logic [9:0] RST_BASE_FRAMES     = 10'd500;
  localparam logic [7:0] RST_FRAMES_PER_STEP = 8'd155;
  localparam logic [6:0] RST_BLINK_COUNT     = 7'd25;

endpackage

[sv/servo_countdown_controller.sv]
// Servo countdown controller: debounce, mode control, countdown and LED color per frame.
//
// One request on the slave stream is one servo frame tick. s_tdata carries the raw
// button level and the pot sample. One request on the master stream is the result of
// that frame: servo pulse length, mode after the frame, press flag and LED color.
// The cfg channel writes the seven setup registers by index and is always ready;
// the user must write it only while no frame is in flight; the block does not enforce this.
//
// A frame goes into an input register, is processed in one pass of short logic with
// one 8 by PotW bit multiply, and its result lands in the output register. One frame
// per cycle is sustained while the receiver takes every result. The output register
// parts the two sides: while the receiver stalls, the block still takes one more
// frame into its input register and only then drops s_tready. The frame state
// advances only when a frame moves into the output register, so nothing is lost or
// repeated under back pressure.
//
// Reset (rst, synchronous) sets the registers to their defaults, puts the block in
// wait mode with the battery color shown and empties both stream registers.
module servo_countdown_controller #(
  parameter int SAMPLE_BITS = scc_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: button_raw [0], pot_sample [8:1], zero [15:9]
  input  logic [15:0]                      s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: servo_long [0], mode [2:1], press_seen [3], led_red [11:4],
  // led_green [19:12], led_blue [27:20], zero [31:28]
  output logic [31:0]                      m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [scc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PotW  = (SAMPLE_BITS < 8) ? SAMPLE_BITS : 8;
  localparam int ProdW = 8 + PotW;

  logic [7:0] battery_code;
  logic [7:0] high_threshold;
  logic [7:0] low_threshold;
  logic [3:0] debounce_samples;
  logic [6:0] blink_reload;
  logic [9:0] base_frames;
  logic [7:0] frames_per_step;

  scc_pkg::mode_t mode_reg, mode_next;
  scc_pkg::show_t led_show, led_show_next;
  logic                         button_stable, button_stable_next;
  logic [3:0]                   debounce_count, debounce_count_next;
  logic                         blink_phase, blink_phase_next;
  logic [6:0]                   blink_count, blink_count_next;
  logic [scc_pkg::FRAMES_W-1:0] frames_left, frames_left_next;

  logic                         in_vld;
  logic                         in_button;
  logic [7:0]                   in_pot;
  logic                         out_vld;
  logic [31:0]                  out_data;
  logic                         advance;

  logic                         press;
  logic [3:0]                   debounce_inc;
  logic [ProdW-1:0]             product;
  logic [scc_pkg::TOTAL_W-1:0]  total;
  logic [scc_pkg::FRAMES_W-1:0] load_frames;
  logic [scc_pkg::FRAMES_W-1:0] frames_dec;
  scc_pkg::rgb_t                color;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld && (!out_vld || m_tready);
  assign s_tready  = !in_vld || advance;
  assign m_tvalid  = out_vld;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_code     <= scc_pkg::RST_BATTERY_CODE;
      high_threshold   <= scc_pkg::RST_HIGH_THRESHOLD;
      low_threshold    <= scc_pkg::RST_LOW_THRESHOLD;
      debounce_samples <= scc_pkg::RST_DEBOUNCE;
      blink_reload     <= scc_pkg::RST_BLINK_RELOAD;
      base_frames      <= scc_pkg::RST_BASE_FRAMES;
      frames_per_step  <= scc_pkg::RST_FRAMES_PER_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scc_pkg::REG_BATTERY_CODE:    battery_code     <= cfg_data[7:0];
        scc_pkg::REG_HIGH_THRESHOLD:  high_threshold   <= cfg_data[7:0];
        scc_pkg::REG_LOW_THRESHOLD:   low_threshold    <= cfg_data[7:0];
        scc_pkg::REG_DEBOUNCE:        debounce_samples <= cfg_data[3:0];
        scc_pkg::REG_BLINK_RELOAD:    blink_reload     <= cfg_data[6:0];
        scc_pkg::REG_BASE_FRAMES:     base_frames      <= cfg_data[9:0];
        scc_pkg::REG_FRAMES_PER_STEP: frames_per_step  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    product      = ProdW'(frames_per_step) * ProdW'(in_pot[PotW-1:0]);
    total        = scc_pkg::TOTAL_W'(base_frames) + scc_pkg::TOTAL_W'(product);
    load_frames  = (total > scc_pkg::TOTAL_W'(scc_pkg::FRAMES_MAX)) ?
                   scc_pkg::FRAMES_MAX : total[scc_pkg::FRAMES_W-1:0];
    frames_dec   = frames_left - scc_pkg::FRAMES_W'(1);
    debounce_inc = debounce_count + 4'd1;

    press               = 1'b0;
    button_stable_next  = button_stable;
    debounce_count_next = 4'd0;
    if (in_button != button_stable) begin
      debounce_count_next = debounce_inc;
      if (debounce_inc >= debounce_samples) begin
        press               = button_stable && !in_button;
        button_stable_next  = in_button;
        debounce_count_next = 4'd0;
      end
    end

    mode_next        = mode_reg;
    led_show_next    = led_show;
    blink_phase_next = blink_phase;
    blink_count_next = blink_count;
    frames_left_next = frames_left;
    unique case (mode_reg)
      scc_pkg::MODE_COUNT: begin
        if (blink_count != 7'd0) begin
          blink_count_next = blink_count - 7'd1;
        end else begin
          led_show_next    = blink_phase ? scc_pkg::SHOW_BATT : scc_pkg::SHOW_OFF;
          blink_phase_next = !blink_phase;
          blink_count_next = blink_reload;
        end
        if (frames_left != '0) begin
          frames_left_next = frames_dec;
          if (frames_dec == '0) begin
            led_show_next = scc_pkg::SHOW_BLUE;
            mode_next     = scc_pkg::MODE_ACTIVE;
          end
        end
      end
      scc_pkg::MODE_ACTIVE: begin
        if (press) begin
          led_show_next = scc_pkg::SHOW_BATT;
          mode_next     = scc_pkg::MODE_WAIT;
        end
      end
      default: begin
        mode_next = scc_pkg::MODE_WAIT;
        if (press) begin
          frames_left_next = load_frames;
          if (load_frames == '0) begin
            led_show_next = scc_pkg::SHOW_BLUE;
            mode_next     = scc_pkg::MODE_ACTIVE;
          end else begin
            led_show_next    = scc_pkg::SHOW_OFF;
            blink_phase_next = 1'b1;
            blink_count_next = blink_reload;
            mode_next        = scc_pkg::MODE_COUNT;
          end
        end
      end
    endcase

    priority if (led_show_next == scc_pkg::SHOW_BLUE) begin
      color = scc_pkg::COLOR_BLUE;
    end else if (led_show_next != scc_pkg::SHOW_BATT) begin
      color = scc_pkg::COLOR_OFF;
    end else if (battery_code <= high_threshold) begin
      color = scc_pkg::COLOR_GREEN;
    end else if (battery_code <= low_threshold) begin
      color = scc_pkg::COLOR_PURPLE;
    end else begin
      color = scc_pkg::COLOR_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld         <= 1'b0;
      out_vld        <= 1'b0;
      mode_reg       <= scc_pkg::MODE_WAIT;
      led_show       <= scc_pkg::SHOW_BATT;
      button_stable  <= 1'b1;
      debounce_count <= 4'd0;
      blink_phase    <= 1'b0;
      blink_count    <= scc_pkg::RST_BLINK_COUNT;
      frames_left    <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_vld <= 1'b1;
      end else if (advance) begin
        in_vld <= 1'b0;
      end
      if (advance) begin
        out_vld        <= 1'b1;
        mode_reg       <= mode_next;
        led_show       <= led_show_next;
        button_stable  <= button_stable_next;
        debounce_count <= debounce_count_next;
        blink_phase    <= blink_phase_next;
        blink_count    <= blink_count_next;
        frames_left    <= frames_left_next;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_button <= s_tdata[0];
      in_pot    <= s_tdata[8:1];
    end
    if (advance) begin
      out_data <= {4'd0, color.blue, color.green, color.red, press,
                   mode_next, mode_reg == scc_pkg::MODE_ACTIVE};
    end
  end

`ifndef NO_ASSERTIONS
  a_count_has_frames: assert property (@(posedge clk) disable iff (rst)
    mode_reg == scc_pkg::MODE_COUNT |-> frames_left != '0)
    else $error("Countdown mode with no frames left.");

  a_count_not_blue: assert property (@(posedge clk) disable iff (rst)
    mode_reg == scc_pkg::MODE_COUNT |-> led_show != scc_pkg::SHOW_BLUE)
    else $error("LED shows blue during countdown.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_vld && out_vld && !m_tready))
    else $error("Input stalled without a full pipeline.");
`endif

endmodule
